// ===== hw/rtl/stok_pkg.sv =====
// Shared types and constants for the streaming source tokenizer.
// Used by the lexer step, the result queue, the top level and the checker.
// No dependencies.
package stok_pkg;

  // Default sizes handed down from the top level
  localparam int POS_BITS_DEF  = 16;
  localparam int IDENT_BUF_DEF = 8;

  // Result queue depth (two results may be pushed per cycle)
  localparam int RES_DEPTH = 4;

  localparam int LEN_W = 16;

  // Token kinds
  localparam logic [5:0] K_EOF         = 6'd0;
  localparam logic [5:0] K_DOT         = 6'd1;
  localparam logic [5:0] K_OPEN_PAREN  = 6'd2;
  localparam logic [5:0] K_CLOSE_PAREN = 6'd3;
  localparam logic [5:0] K_OPEN_BRACE  = 6'd4;
  localparam logic [5:0] K_CLOSE_BRACE = 6'd5;
  localparam logic [5:0] K_OPEN_SQUARE = 6'd6;
  localparam logic [5:0] K_CLOSE_SQUARE = 6'd7;
  localparam logic [5:0] K_AND         = 6'd8;
  localparam logic [5:0] K_ADD_EQ      = 6'd9;
  localparam logic [5:0] K_ADD         = 6'd10;
  localparam logic [5:0] K_SUB_GT      = 6'd11;
  localparam logic [5:0] K_SUB_EQ      = 6'd12;
  localparam logic [5:0] K_SUB         = 6'd13;
  localparam logic [5:0] K_MUL_EQ      = 6'd14;
  localparam logic [5:0] K_MUL         = 6'd15;
  localparam logic [5:0] K_DIV_EQ      = 6'd16;
  localparam logic [5:0] K_DIV         = 6'd17;
  localparam logic [5:0] K_COMMA       = 6'd18;
  localparam logic [5:0] K_COLON       = 6'd19;
  localparam logic [5:0] K_SEMICOLON   = 6'd20;
  localparam logic [5:0] K_LE          = 6'd21;
  localparam logic [5:0] K_LT          = 6'd22;
  localparam logic [5:0] K_GE          = 6'd23;
  localparam logic [5:0] K_GT          = 6'd24;
  localparam logic [5:0] K_DEQ         = 6'd25;
  localparam logic [5:0] K_EQ          = 6'd26;
  localparam logic [5:0] K_STRING      = 6'd27;
  localparam logic [5:0] K_FUNCTION    = 6'd28;
  localparam logic [5:0] K_IF          = 6'd29;
  localparam logic [5:0] K_ELSE        = 6'd30;
  localparam logic [5:0] K_WHILE       = 6'd31;
  localparam logic [5:0] K_FOR         = 6'd32;
  localparam logic [5:0] K_LET         = 6'd33;
  localparam logic [5:0] K_STRUCT      = 6'd34;
  localparam logic [5:0] K_RETURN      = 6'd35;
  localparam logic [5:0] K_IDENT       = 6'd36;
  localparam logic [5:0] K_FLOAT       = 6'd37;
  localparam logic [5:0] K_INT         = 6'd38;
  localparam logic [5:0] K_UNEXP       = 6'd39;

  // Lexer mode
  typedef enum logic [3:0] {
    M_IDLE, M_PLUS, M_MINUS, M_STAR, M_SLASH, M_LT, M_GT, M_EQ,
    M_IDENT, M_INT, M_FLOAT, M_STRING, M_COMMENT
  } lex_mode_t;

  // Input item
  typedef struct packed {
    logic [7:0] ch;
    logic       end_mark;
  } stok_in_t;

  // Result item
  typedef struct packed {
    logic [5:0]       kind;
    logic [LEN_W-1:0] start_res;
    logic [LEN_W-1:0] length;
    logic             run_last;
  } stok_out_t;

  // Up to two results produced by one step, in order
  typedef struct packed {
    logic      v0;
    logic      v1;
    stok_out_t r0;
    stok_out_t r1;
  } stok_push_t;

endpackage

// ===== hw/rtl/stok_lexer.sv =====
// Lexer step: mode, offsets and identifier buffer, plus the combinational
// transition that turns one byte into zero, one or two tokens.
// Depends on stok_pkg.
module stok_lexer
  import stok_pkg::*;
#(
  parameter int POS_BITS  = POS_BITS_DEF,
  parameter int IDENT_BUF = IDENT_BUF_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  stok_in_t   item,
  output stok_push_t push
);

  localparam int IL_W = $clog2(IDENT_BUF + 2);
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  // Keyword table, text right-justified
  localparam logic [63:0] KW_TEXT [8] = '{
    64'("function"), 64'("if"), 64'("else"), 64'("while"),
    64'("for"), 64'("let"), 64'("struct"), 64'("return")
  };
  localparam int KW_LEN [8] = '{8, 2, 4, 5, 3, 3, 6, 6};
  localparam logic [5:0] KW_KIND [8] = '{
    K_FUNCTION, K_IF, K_ELSE, K_WHILE, K_FOR, K_LET, K_STRUCT, K_RETURN
  };

  // State
  lex_mode_t           mode_r, mode_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] tstart_r, tstart_nxt;
  logic [7:0]          chars_r [IDENT_BUF];
  logic [7:0]          chars_nxt [IDENT_BUF];
  logic                too_long_r, too_long_nxt;
  logic [IL_W-1:0]     ilen_r, ilen_nxt;

  logic [7:0]          c;
  logic                endm;
  logic [POS_BITS-1:0] p, p1;
  logic c_alpha, c_digit, c_space, c_ident_start, c_identch;
  logic [5:0] single_k;
  lex_mode_t  op_mode;
  logic [5:0] two_k;
  logic       is_op_mode;
  logic       close_run;
  logic       run_idle;
  logic [5:0] ident_k;
  logic [5:0] pend_k;

  // Pack a token into a result: start offset low bits, saturated length
  function automatic stok_out_t mk_res(input logic [5:0] kind,
                                       input logic [POS_BITS-1:0] s,
                                       input logic [POS_BITS-1:0] e,
                                       input logic last);
    logic [POS_BITS-1:0] d;
    stok_out_t           r;
    d = (e > s) ? e - s : '0;
    r.kind      = kind;
    r.start_res = LEN_W'(s);
    r.length    = (d > POS_BITS'({LEN_W{1'b1}})) ? {LEN_W{1'b1}} : LEN_W'(d);
    r.run_last  = last;
    return r;
  endfunction

  assign c    = item.ch;
  assign endm = item.end_mark;
  assign p    = pos_r;
  assign p1   = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;

  // Character classes
  assign c_alpha       = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign c_digit       = (c >= "0" && c <= "9");
  assign c_space       = (c == " ") || (c == "\n") || (c == "\t");
  assign c_ident_start = c_alpha || (c == "_");
  assign c_identch     = c_ident_start || c_digit;

  // Single-character punctuation
  always_comb begin
    case (c)
      ".":     single_k = K_DOT;
      "(":     single_k = K_OPEN_PAREN;
      ")":     single_k = K_CLOSE_PAREN;
      "{":     single_k = K_OPEN_BRACE;
      "}":     single_k = K_CLOSE_BRACE;
      "[":     single_k = K_OPEN_SQUARE;
      "]":     single_k = K_CLOSE_SQUARE;
      "&":     single_k = K_AND;
      ",":     single_k = K_COMMA;
      ":":     single_k = K_COLON;
      ";":     single_k = K_SEMICOLON;
      default: single_k = K_EOF;
    endcase
  end

  // Characters that open a pending token
  always_comb begin
    case (c)
      "+":     op_mode = M_PLUS;
      "-":     op_mode = M_MINUS;
      "*":     op_mode = M_STAR;
      "/":     op_mode = M_SLASH;
      "<":     op_mode = M_LT;
      ">":     op_mode = M_GT;
      "=":     op_mode = M_EQ;
      "\"":    op_mode = M_STRING;
      default: op_mode = M_IDLE;
    endcase
  end

  assign is_op_mode = mode_r inside {M_PLUS, M_MINUS, M_STAR, M_SLASH, M_LT, M_GT, M_EQ};

  // Two-character operators
  always_comb begin
    two_k = K_EOF;
    if (mode_r == M_MINUS && c == ">") begin
      two_k = K_SUB_GT;
    end else if (c == "=") begin
      case (mode_r)
        M_PLUS:  two_k = K_ADD_EQ;
        M_MINUS: two_k = K_SUB_EQ;
        M_STAR:  two_k = K_MUL_EQ;
        M_SLASH: two_k = K_DIV_EQ;
        M_LT:    two_k = K_LE;
        M_GT:    two_k = K_GE;
        M_EQ:    two_k = K_DEQ;
        default: two_k = K_EOF;
      endcase
    end
  end

  // Keyword match over the identifier buffer
  always_comb begin
    logic hit;
    ident_k = K_IDENT;
    for (int k = 0; k < 8; k++) begin
      hit = (ilen_r == IL_W'(KW_LEN[k]));
      for (int i = 0; i < 8; i++) begin
        if (i < KW_LEN[k]) begin
          hit = hit && (chars_r[i] == KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8]);
        end
      end
      if (hit && !too_long_r) begin
        ident_k = KW_KIND[k];
      end
    end
  end

  // Kind of the pending token when something else closes it
  always_comb begin
    case (mode_r)
      M_PLUS:   pend_k = K_ADD;
      M_MINUS:  pend_k = K_SUB;
      M_STAR:   pend_k = K_MUL;
      M_SLASH:  pend_k = K_DIV;
      M_LT:     pend_k = K_LT;
      M_GT:     pend_k = K_GT;
      M_EQ:     pend_k = K_EQ;
      M_IDENT:  pend_k = ident_k;
      M_INT:    pend_k = K_INT;
      M_FLOAT:  pend_k = K_FLOAT;
      M_STRING: pend_k = K_STRING;
      default:  pend_k = K_EOF;
    endcase
  end

  // Pending token closed by this byte, which then starts afresh
  always_comb begin
    close_run = 1'b0;
    if (mode_r == M_IDENT) begin
      close_run = !c_identch;
    end else if (mode_r == M_INT || mode_r == M_FLOAT) begin
      close_run = !c_digit && !(mode_r == M_INT && c == ".");
    end else if (is_op_mode) begin
      close_run = !(mode_r == M_SLASH && c == "/") && (two_k == K_EOF);
    end
  end

  assign run_idle = (mode_r == M_IDLE) || close_run;

  // Next state
  always_comb begin
    mode_nxt     = mode_r;
    pos_nxt      = pos_r;
    tstart_nxt   = tstart_r;
    chars_nxt    = chars_r;
    too_long_nxt = too_long_r;
    ilen_nxt     = ilen_r;
    if (endm) begin
      mode_nxt     = M_IDLE;
      pos_nxt      = '0;
      tstart_nxt   = '0;
      for (int i = 0; i < IDENT_BUF; i++) chars_nxt[i] = '0;
      too_long_nxt = 1'b0;
      ilen_nxt     = '0;
    end else begin
      pos_nxt = p1;
      case (mode_r)
        M_COMMENT: if (c == "\n") mode_nxt = M_IDLE;
        M_STRING:  if (c == "\"") mode_nxt = M_IDLE;
        M_IDENT: begin
          if (c_identch) begin
            if (ilen_r < IL_W'(IDENT_BUF)) begin
              for (int i = 0; i < IDENT_BUF; i++) begin
                if (ilen_r == IL_W'(i)) chars_nxt[i] = c;
              end
              ilen_nxt = ilen_r + 1'b1;
            end else begin
              too_long_nxt = 1'b1;
              ilen_nxt     = IL_W'(IDENT_BUF + 1);
            end
          end
        end
        M_INT: if (!c_digit && c == ".") mode_nxt = M_FLOAT;
        default: begin
          if (mode_r == M_SLASH && c == "/") begin
            mode_nxt = M_COMMENT;
          end else if (is_op_mode && two_k != K_EOF) begin
            mode_nxt = M_IDLE;
          end
        end
      endcase
      if (close_run) mode_nxt = M_IDLE;
      // Start of a new token
      if (run_idle && single_k == K_EOF) begin
        tstart_nxt = p;
        if (op_mode != M_IDLE) begin
          mode_nxt = op_mode;
          if (op_mode == M_STRING) tstart_nxt = p1;
        end else if (c_ident_start) begin
          for (int i = 0; i < IDENT_BUF; i++) chars_nxt[i] = '0;
          chars_nxt[0] = c;
          ilen_nxt     = IL_W'(1);
          too_long_nxt = 1'b0;
          mode_nxt     = M_IDENT;
        end else if (c_digit) begin
          mode_nxt = M_INT;
        end
      end
    end
  end

  // Token output: closing token first, then a one-byte or end token
  always_comb begin
    logic       v0, v1;
    logic [5:0] k0, k1;
    logic [POS_BITS-1:0] s0, e0, s1, e1;
    v0 = 1'b0; k0 = K_EOF; s0 = tstart_r; e0 = p;
    v1 = 1'b0; k1 = K_EOF; s1 = p;        e1 = p1;
    if (endm) begin
      v0 = (mode_r != M_IDLE) && (mode_r != M_COMMENT);
      k0 = pend_k;
      v1 = 1'b1;
      e1 = p;
    end else begin
      if (mode_r == M_STRING && c == "\"") begin
        v0 = 1'b1; k0 = K_STRING;
      end else if (is_op_mode && two_k != K_EOF) begin
        v0 = 1'b1; k0 = two_k; e0 = p1;
      end else if (close_run) begin
        v0 = 1'b1; k0 = pend_k;
      end
      if (run_idle) begin
        if (single_k != K_EOF) begin
          v1 = 1'b1; k1 = single_k;
        end else if (op_mode == M_IDLE && !c_space && !c_ident_start && !c_digit) begin
          v1 = 1'b1; k1 = K_UNEXP;
        end
      end
    end
    push.v0 = step_en && v0;
    push.v1 = step_en && v1;
    push.r0 = mk_res(k0, s0, e0, !v1);
    push.r1 = mk_res(k1, s1, e1, 1'b1);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_IDLE;
      pos_r      <= '0;
      tstart_r   <= '0;
      for (int i = 0; i < IDENT_BUF; i++) chars_r[i] <= '0;
      too_long_r <= 1'b0;
      ilen_r     <= '0;
    end else if (step_en) begin
      mode_r     <= mode_nxt;
      pos_r      <= pos_nxt;
      tstart_r   <= tstart_nxt;
      chars_r    <= chars_nxt;
      too_long_r <= too_long_nxt;
      ilen_r     <= ilen_nxt;
    end
  end

endmodule

// ===== hw/rtl/stok_out_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on stok_pkg.
module stok_out_fifo
  import stok_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  stok_push_t push,
  output logic       room,
  output logic       out_valid,
  input  logic       out_stall,
  output stok_out_t  out_data
);

  localparam int PW = $clog2(RES_DEPTH);
  localparam int CW = $clog2(RES_DEPTH + 1);

  stok_out_t       mem_r [RES_DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            pop;
  logic [1:0]      push_n;
  stok_out_t       first;

  assign pop       = out_valid && !out_stall;
  assign push_n    = 2'(push.v0) + 2'(push.v1);
  assign first     = push.v0 ? push.r0 : push.r1;
  assign room      = cnt_r <= CW'(RES_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_data  = mem_r[rd_r];

  // Pointer and fill count
  always_comb begin
    wr_nxt  = wr_r + PW'(push_n);
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + CW'(push_n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry writes
  always_ff @(posedge clk) begin
    if (push.v0 || push.v1) mem_r[wr_r] <= first;
    if (push.v0 && push.v1) mem_r[wr_r + 1'b1] <= push.r1;
  end

endmodule

// ===== hw/rtl/source_tokenizer_core.sv =====
// Streaming tokenizer: one source byte per cycle while the result queue has room,
// tokens out as kind/start/length. A byte passes the input register, then one lexer
// step (held while the queue lacks room) into the 4-entry result queue, and its result
// then shows on out_valid. Throughput: one byte per cycle while the queue holds at most
// two results; a byte that yields two tokens needs two output transfers. Synchronous
// active-low reset clears all lexer state, the input valid flag and the result queue.
module source_tokenizer_core
  import stok_pkg::*;
#(
  parameter int POS_BITS  = POS_BITS_DEF,
  parameter int IDENT_BUF = IDENT_BUF_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  stok_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output stok_out_t out_data
);

  stok_in_t   in_data_r;
  logic       in_vld_r, in_vld_nxt;
  logic       room;
  logic       step_en;
  stok_push_t push;

  // Input register advances whenever the queue can absorb two results
  assign step_en  = in_vld_r && room;
  assign in_stall = in_vld_r && !room;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && !in_stall) begin
      in_vld_nxt = 1'b1;
    end else if (step_en) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_data_r <= in_data;
  end

  stok_lexer #(
    .POS_BITS  (POS_BITS),
    .IDENT_BUF (IDENT_BUF)
  ) u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_data_r),
    .push    (push)
  );

  stok_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/stok_checker.sv =====
// Port-level checks for the tokenizer core, bound to the top level.
// Depends on stok_pkg and source_tokenizer_core.
module stok_checker
  import stok_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input stok_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input stok_out_t out_data
);

  // A stalled byte stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input changed");

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Only defined kinds come out
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.kind <= K_UNEXP)
    else $error("kind out of range");

  // End token is empty and closes its byte's results
  a_eof_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == K_EOF |-> out_data.run_last && out_data.length == '0)
    else $error("malformed end token");

  // Two-character operators are at most two bytes and stand alone
  a_two_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == K_ADD_EQ || out_data.kind == K_SUB_GT ||
                  out_data.kind == K_SUB_EQ || out_data.kind == K_MUL_EQ ||
                  out_data.kind == K_DIV_EQ || out_data.kind == K_LE ||
                  out_data.kind == K_GE || out_data.kind == K_DEQ)
    |-> out_data.run_last && out_data.length <= 16'd2)
    else $error("bad two-character operator");

endmodule

bind source_tokenizer_core stok_checker u_stok_checker (.*);
